// File: src/mbps_pkg.sv
package mbps_pkg;

	localparam int unsigned OFS_W      = 48;
	localparam int unsigned CNT_W      = 21;
	localparam int unsigned LEN_CFG_W  = 5;
	localparam int unsigned IDX_W      = 7;
	localparam int unsigned APB_AW     = 6;
	localparam int unsigned APB_DW     = 64;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = 2;
	localparam int unsigned FIFO_CNT_W = 3;

	localparam logic [OFS_W-1:0] OFS_MAX = '1;

	typedef enum logic [2:0] {
		KIND_HIT        = 3'd0,
		KIND_DONE       = 3'd1,
		KIND_TRUNC      = 3'd2,
		KIND_SHORT      = 3'd3,
		KIND_MASK_EMPTY = 3'd4
	} result_kind_t;

	typedef enum logic [2:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_MASK_LOW       = 3'd2,
		REG_MASK_HIGH      = 3'd3,
		REG_PATTERN_LENGTH = 3'd4,
		REG_HIT_LIMIT      = 3'd5,
		REG_START_OFFSET   = 3'd6,
		REG_MATCHES_BEFORE = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic [63:0]          pattern_low;
		logic [63:0]          pattern_high;
		logic [63:0]          mask_low;
		logic [63:0]          mask_high;
		logic [LEN_CFG_W-1:0] pattern_length;
		logic [CNT_W-1:0]     hit_limit;
		logic [OFS_W-1:0]     start_offset;
		logic [OFS_W-1:0]     matches_before;
	} cfg_t;

	typedef struct packed {
		result_kind_t     kind;
		logic [OFS_W-1:0] position;
		logic [OFS_W-1:0] total;
		logic             exact;
		logic             last;
	} result_t;

	// byte idx of the 128-bit lo/hi pair; bytes from 16 upward read as zero
	function automatic logic [7:0] reg_byte(logic [63:0] lo, logic [63:0] hi,
		logic [IDX_W-1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		if (idx < IDX_W'(8)) begin
			b = lo[{idx[2:0], 3'b000} +: 8];
		end else if (idx < IDX_W'(16)) begin
			b = hi[{idx[2:0], 3'b000} +: 8];
		end
		return b;
	endfunction

endpackage

// File: src/mbps_cfg.sv
module mbps_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mbps_pkg::APB_AW-1:0]   paddr,
	input  logic [mbps_pkg::APB_DW-1:0]   pwdata,
	output logic [mbps_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output mbps_pkg::cfg_t                cfg
);

	mbps_pkg::cfg_t     cfg_q;
	mbps_pkg::reg_index_t idx;
	logic               wr_en;

	assign idx    = mbps_pkg::reg_index_t'(paddr[5:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_low    <= '0;
			cfg_q.pattern_high   <= '0;
			cfg_q.mask_low       <= '1;
			cfg_q.mask_high      <= '1;
			cfg_q.pattern_length <= mbps_pkg::LEN_CFG_W'(1);
			cfg_q.hit_limit      <= mbps_pkg::CNT_W'(1);
			cfg_q.start_offset   <= '0;
			cfg_q.matches_before <= '0;
		end else if (wr_en) begin
			unique case (idx)
				mbps_pkg::REG_PATTERN_LOW:    cfg_q.pattern_low  <= pwdata;
				mbps_pkg::REG_PATTERN_HIGH:   cfg_q.pattern_high <= pwdata;
				mbps_pkg::REG_MASK_LOW:       cfg_q.mask_low     <= pwdata;
				mbps_pkg::REG_MASK_HIGH:      cfg_q.mask_high    <= pwdata;
				mbps_pkg::REG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= pwdata[mbps_pkg::LEN_CFG_W-1:0];
				end
				mbps_pkg::REG_HIT_LIMIT:      cfg_q.hit_limit <= pwdata[mbps_pkg::CNT_W-1:0];
				mbps_pkg::REG_START_OFFSET:   begin
					cfg_q.start_offset <= pwdata[mbps_pkg::OFS_W-1:0];
				end
				mbps_pkg::REG_MATCHES_BEFORE: begin
					cfg_q.matches_before <= pwdata[mbps_pkg::OFS_W-1:0];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			mbps_pkg::REG_PATTERN_LOW:    prdata = cfg_q.pattern_low;
			mbps_pkg::REG_PATTERN_HIGH:   prdata = cfg_q.pattern_high;
			mbps_pkg::REG_MASK_LOW:       prdata = cfg_q.mask_low;
			mbps_pkg::REG_MASK_HIGH:      prdata = cfg_q.mask_high;
			mbps_pkg::REG_PATTERN_LENGTH: prdata = mbps_pkg::APB_DW'(cfg_q.pattern_length);
			mbps_pkg::REG_HIT_LIMIT:      prdata = mbps_pkg::APB_DW'(cfg_q.hit_limit);
			mbps_pkg::REG_START_OFFSET:   prdata = mbps_pkg::APB_DW'(cfg_q.start_offset);
			mbps_pkg::REG_MATCHES_BEFORE: prdata = mbps_pkg::APB_DW'(cfg_q.matches_before);
			default:                      prdata = '0;
		endcase
	end

endmodule

// File: src/mbps_cell.sv
module mbps_cell (
	input  logic       clk,
	input  logic       shift,
	input  logic [7:0] byte_in,
	input  logic [7:0] pat_byte,
	input  logic [7:0] mask_byte,
	input  logic       active,
	output logic [7:0] held_byte,
	output logic       cmp_ok
);

	logic [7:0] win_q;

	// compares the byte it is about to take, i.e. the window after this shift
	assign cmp_ok    = !active || ((byte_in & mask_byte) == (pat_byte & mask_byte));
	assign held_byte = win_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			win_q <= byte_in;
		end
	end

endmodule

// File: src/mbps_result_fifo.sv
module mbps_result_fifo (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push0,
	input  logic                              push1,
	input  mbps_pkg::result_t                 wdata0,
	input  mbps_pkg::result_t                 wdata1,
	input  logic                              pop,
	output logic                              rvalid,
	output mbps_pkg::result_t                 rdata,
	output logic [mbps_pkg::FIFO_CNT_W-1:0]   count
);

	mbps_pkg::result_t                   mem_q [mbps_pkg::FIFO_DEPTH];
	logic [mbps_pkg::FIFO_PTR_W-1:0]     wptr_q;
	logic [mbps_pkg::FIFO_PTR_W-1:0]     rptr_q;
	logic [mbps_pkg::FIFO_CNT_W-1:0]     count_q;
	logic [mbps_pkg::FIFO_PTR_W-1:0]     wptr_nx;
	logic                                do_pop;

	assign wptr_nx = wptr_q + mbps_pkg::FIFO_PTR_W'(1);
	assign rvalid  = (count_q != '0);
	assign rdata   = mem_q[rptr_q];
	assign count   = count_q;
	assign do_pop  = pop && rvalid;

	always_ff @(posedge clk) begin
		if (push0) begin
			mem_q[wptr_q] <= wdata0;
		end
		if (push1) begin
			mem_q[wptr_nx] <= wdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + mbps_pkg::FIFO_PTR_W'(push0) + mbps_pkg::FIFO_PTR_W'(push1);
			rptr_q  <= rptr_q + mbps_pkg::FIFO_PTR_W'(do_pop);
			count_q <= count_q + mbps_pkg::FIFO_CNT_W'(push0) + mbps_pkg::FIFO_CNT_W'(push1)
				- mbps_pkg::FIFO_CNT_W'(do_pop);
		end
	end

endmodule

// File: src/masked_byte_pattern_search_core.sv
// Each accepted byte is registered in the compare stage, then its results are written
// into the result queue. Throughput: one byte per clock while that queue holds two
// entries or fewer; a byte that yields a hit and the closing result writes two queue
// entries. The compare stage and the four-entry result queue set this.
// Reset: configuration returns to its defaults and the run state clears; the window
// bytes in the cells carry no reset.
module masked_byte_pattern_search_core #(
	parameter int unsigned MAX_PATTERN = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mbps_pkg::APB_AW-1:0]   paddr,
	input  logic [mbps_pkg::APB_DW-1:0]   pwdata,
	output logic [mbps_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	input  logic                          byte_valid,
	output logic                          byte_stall,
	input  logic [7:0]                    data_byte,
	input  logic                          end_of_range,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [2:0]                    result_kind,
	output logic [mbps_pkg::OFS_W-1:0]    position,
	output logic [mbps_pkg::OFS_W-1:0]    match_total,
	output logic                          total_exact,
	output logic                          run_last
);

	localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int unsigned CW    = (LEN_W > mbps_pkg::LEN_CFG_W) ? LEN_W : mbps_pkg::LEN_CFG_W;

	mbps_pkg::cfg_t cfg;

	mbps_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---------------- stage 1: window chain and compare ----------------
	logic                         accept;
	logic                         adv;
	logic [CW-1:0]                len_raw;
	logic [CW-1:0]                len_eff;
	logic [7:0]                   held   [MAX_PATTERN];
	logic [MAX_PATTERN-1:0]       cmp_ok;
	logic [MAX_PATTERN-1:0]       mask_nz;
	logic [mbps_pkg::OFS_W-1:0]   bs_q;
	logic [mbps_pkg::OFS_W-1:0]   bs_new;
	logic [mbps_pkg::OFS_W-1:0]   len_ext;

	assign len_raw = CW'(cfg.pattern_length);

	always_comb begin
		len_eff = len_raw;
		if (len_raw == '0) begin
			len_eff = CW'(1);
		end else if (len_raw > CW'(MAX_PATTERN)) begin
			len_eff = CW'(MAX_PATTERN);
		end
	end

	assign len_ext = mbps_pkg::OFS_W'(len_eff);

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic [7:0]    byte_in;
		logic [CW-1:0] pidx;
		logic          active;
		logic [7:0]    pat_b;
		logic [7:0]    mask_b;

		// cell k holds the byte k places back; it meets pattern byte len-1-k
		assign pidx   = len_eff - CW'(k) - CW'(1);
		assign active = (CW'(k) < len_eff);
		assign pat_b  = mbps_pkg::reg_byte(cfg.pattern_low, cfg.pattern_high,
			mbps_pkg::IDX_W'(pidx));
		assign mask_b = mbps_pkg::reg_byte(cfg.mask_low, cfg.mask_high,
			mbps_pkg::IDX_W'(pidx));
		assign mask_nz[k] = active && (mask_b != 8'h00);

		if (k == 0) begin : g_head
			assign byte_in = data_byte;
		end else begin : g_link
			assign byte_in = held[k-1];
		end

		mbps_cell u_cell (
			.clk       (clk),
			.shift     (accept),
			.byte_in   (byte_in),
			.pat_byte  (pat_b),
			.mask_byte (mask_b),
			.active    (active),
			.held_byte (held[k]),
			.cmp_ok    (cmp_ok[k])
		);
	end

	assign bs_new = (bs_q == mbps_pkg::OFS_MAX) ? bs_q : bs_q + mbps_pkg::OFS_W'(1);

	logic                       valid_s1;
	logic                       last_s1;
	logic                       mask_err_s1;
	logic                       short_s1;
	logic                       match_s1;
	logic [mbps_pkg::OFS_W-1:0] pos_s1;

	assign byte_stall = valid_s1 && !adv;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q     <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				bs_q     <= end_of_range ? '0 : bs_new;
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1     <= end_of_range;
			mask_err_s1 <= (bs_q == '0) && (mask_nz == '0);
			short_s1    <= (bs_new < len_ext);
			match_s1    <= (bs_new >= len_ext) && (&cmp_ok);
			pos_s1      <= cfg.start_offset + bs_new - len_ext;
		end
	end

	// ---------------- stage 2: run bookkeeping and results ----------------
	logic [mbps_pkg::FIFO_CNT_W-1:0] fifo_count;
	logic                            fire2;
	logic [mbps_pkg::CNT_W-1:0]      ph_q;
	logic [mbps_pkg::OFS_W-1:0]      resume_q;
	logic                            stopped_q;
	logic [mbps_pkg::OFS_W:0]        sum;
	logic [mbps_pkg::OFS_W-1:0]      total;
	logic                            trunc;
	logic                            hit_v;
	logic                            fin_v;
	logic                            stop_now;
	mbps_pkg::result_t               hit_res;
	mbps_pkg::result_t               fin_res;
	logic                            push0;
	logic                            push1;
	mbps_pkg::result_t               wdata0;
	mbps_pkg::result_t               head;

	assign adv   = (fifo_count <= mbps_pkg::FIFO_CNT_W'(mbps_pkg::FIFO_DEPTH - 2));
	assign fire2 = valid_s1 && adv;

	// one saturating add serves hit, done and truncated totals
	assign sum   = {1'b0, cfg.matches_before} + (mbps_pkg::OFS_W + 1)'(ph_q)
		+ (mbps_pkg::OFS_W + 1)'(match_s1);
	assign total = sum[mbps_pkg::OFS_W] ? mbps_pkg::OFS_MAX : sum[mbps_pkg::OFS_W-1:0];
	assign trunc = match_s1 && (ph_q >= cfg.hit_limit);

	always_comb begin
		hit_res          = '0;
		hit_res.kind     = mbps_pkg::KIND_HIT;
		hit_res.position = pos_s1;
		hit_res.total    = total;
		fin_res          = '0;
		fin_res.kind     = mbps_pkg::KIND_DONE;
		fin_res.last     = 1'b1;
		hit_v            = 1'b0;
		fin_v            = 1'b0;
		stop_now         = 1'b0;
		if (!stopped_q) begin
			priority if (mask_err_s1) begin
				fin_v        = 1'b1;
				stop_now     = 1'b1;
				fin_res.kind = mbps_pkg::KIND_MASK_EMPTY;
			end else if (trunc) begin
				fin_v            = 1'b1;
				stop_now         = 1'b1;
				fin_res.kind     = mbps_pkg::KIND_TRUNC;
				fin_res.position = (ph_q == '0) ? cfg.start_offset : resume_q;
				fin_res.total    = total;
			end else begin
				hit_v = match_s1;
				if (last_s1) begin
					fin_v = 1'b1;
					if (short_s1) begin
						fin_res.kind = mbps_pkg::KIND_SHORT;
					end else begin
						fin_res.total = total;
						fin_res.exact = 1'b1;
					end
				end
			end
		end
	end

	assign push0  = fire2 && (hit_v || fin_v);
	assign push1  = fire2 && hit_v && fin_v;
	assign wdata0 = hit_v ? hit_res : fin_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q      <= '0;
			resume_q  <= '0;
			stopped_q <= 1'b0;
		end else if (fire2) begin
			if (last_s1) begin
				ph_q      <= '0;
				resume_q  <= '0;
				stopped_q <= 1'b0;
			end else begin
				if (stop_now) begin
					stopped_q <= 1'b1;
				end
				if (hit_v) begin
					ph_q     <= ph_q + mbps_pkg::CNT_W'(1);
					resume_q <= pos_s1 + mbps_pkg::OFS_W'(1);
				end
			end
		end
	end

	mbps_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (push0),
		.push1  (push1),
		.wdata0 (wdata0),
		.wdata1 (fin_res),
		.pop    (!result_stall),
		.rvalid (result_valid),
		.rdata  (head),
		.count  (fifo_count)
	);

	assign result_kind = head.kind;
	assign position    = head.position;
	assign match_total = head.total;
	assign total_exact = head.exact;
	assign run_last    = head.last;

endmodule

// File: src/mbps_checker.sv
module mbps_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       result_valid,
	input logic                       result_stall,
	input logic [2:0]                 result_kind,
	input logic [mbps_pkg::OFS_W-1:0] position,
	input logic [mbps_pkg::OFS_W-1:0] match_total,
	input logic                       total_exact,
	input logic                       run_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_kind)
			&& $stable(position) && $stable(match_total) && $stable(total_exact)
			&& $stable(run_last))
		else $error("stalled result changed");

	a_exact_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && total_exact |-> result_kind == mbps_pkg::KIND_DONE)
		else $error("exact total on a result other than done");

	a_last_vs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result_kind == mbps_pkg::KIND_HIT) != run_last))
		else $error("run_last disagrees with result kind");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_kind == mbps_pkg::KIND_SHORT
			|| result_kind == mbps_pkg::KIND_MASK_EMPTY)
		|-> position == '0 && match_total == '0)
		else $error("error result carries nonzero position or total");

endmodule

bind masked_byte_pattern_search_core mbps_checker u_mbps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_kind  (result_kind),
	.position     (position),
	.match_total  (match_total),
	.total_exact  (total_exact),
	.run_last     (run_last)
);

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import mbps_pkg::*;

	localparam int unsigned ITEM_TARGET  = 1100;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef logic [7:0] byte_q_t[$];

	// Tracks the run state of the search and the results it must produce.
	class search_scoreboard;
		logic [63:0]          pat_lo, pat_hi, msk_lo, msk_hi;
		logic [LEN_CFG_W-1:0] len_cfg;
		logic [CNT_W-1:0]     hit_limit;
		logic [OFS_W-1:0]     start_ofs, hits_before;
		logic [7:0]           window[16];
		logic [OFS_W-1:0]     seen, resume_ofs;
		logic [CNT_W-1:0]     page_hits;
		bit                   stopped;
		result_t              pending[$];
		int unsigned          errors;

		function new();
			pat_lo = '0;
			pat_hi = '0;
			msk_lo = '1;
			msk_hi = '1;
			len_cfg = LEN_CFG_W'(1);
			hit_limit = CNT_W'(1);
			start_ofs = '0;
			hits_before = '0;
			errors = 0;
			clear_run();
		endfunction

		function void clear_run();
			foreach (window[i]) window[i] = 8'h00;
			seen = '0;
			resume_ofs = '0;
			page_hits = '0;
			stopped = 1'b0;
		endfunction

		function void set_reg(reg_index_t idx, logic [63:0] v);
			case (idx)
				REG_PATTERN_LOW:    pat_lo = v;
				REG_PATTERN_HIGH:   pat_hi = v;
				REG_MASK_LOW:       msk_lo = v;
				REG_MASK_HIGH:      msk_hi = v;
				REG_PATTERN_LENGTH: len_cfg = v[LEN_CFG_W-1:0];
				REG_HIT_LIMIT:      hit_limit = v[CNT_W-1:0];
				REG_START_OFFSET:   start_ofs = v[OFS_W-1:0];
				REG_MATCHES_BEFORE: hits_before = v[OFS_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [OFS_W-1:0] sat_sum(logic [OFS_W-1:0] a, logic [OFS_W-1:0] b);
			logic [OFS_W:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[OFS_W] ? OFS_MAX : s[OFS_W-1:0];
		endfunction

		function logic [7:0] byte_of(logic [63:0] lo, logic [63:0] hi, int i);
			logic [127:0] both;
			both = {hi, lo};
			return both[i*8 +: 8];
		endfunction

		function void add_result(result_kind_t k, logic [OFS_W-1:0] p, logic [OFS_W-1:0] t,
			logic ex, logic ls);
			result_t r;
			r.kind = k;
			r.position = p;
			r.total = t;
			r.exact = ex;
			r.last = ls;
			pending = {pending, r};
		endfunction

		// Returns 1 when the byte was scanned, 0 when a stopped run ignored it.
		function bit take_byte(logic [7:0] b, logic eor);
			int               len;
			logic [7:0]       any;
			bit               hit;
			logic [OFS_W-1:0] pos;
			if (stopped) begin
				if (eor) clear_run();
				return 1'b0;
			end
			len = (len_cfg == 0) ? 1 : (len_cfg > 16) ? 16 : int'(len_cfg);
			if (seen == 0) begin
				any = 8'h00;
				for (int i = 0; i < len; i++) any |= byte_of(msk_lo, msk_hi, i);
				if (any == 8'h00) begin
					add_result(KIND_MASK_EMPTY, '0, '0, 1'b0, 1'b1);
					if (eor) clear_run();
					else stopped = 1'b1;
					return 1'b1;
				end
			end
			for (int i = 15; i > 0; i--) window[i] = window[i-1];
			window[0] = b;
			if (seen != OFS_MAX) seen++;
			if (seen >= len) begin
				hit = 1'b1;
				// pattern byte 0 lines up with the oldest byte of the window
				for (int i = 0; i < len; i++) begin
					if (((window[len-1-i] ^ byte_of(pat_lo, pat_hi, i))
						& byte_of(msk_lo, msk_hi, i)) != 8'h00) hit = 1'b0;
				end
				if (hit) begin
					pos = start_ofs + seen - OFS_W'(len);
					if (page_hits >= hit_limit) begin
						add_result(KIND_TRUNC, (page_hits == 0) ? start_ofs : resume_ofs,
							sat_sum(sat_sum(hits_before, OFS_W'(page_hits)), OFS_W'(1)),
							1'b0, 1'b1);
						if (eor) clear_run();
						else stopped = 1'b1;
						return 1'b1;
					end
					page_hits++;
					resume_ofs = pos + 1'b1;
					add_result(KIND_HIT, pos, sat_sum(hits_before, OFS_W'(page_hits)), 1'b0, 1'b0);
				end
			end
			if (eor) begin
				if (seen < len) add_result(KIND_SHORT, '0, '0, 1'b0, 1'b1);
				else add_result(KIND_DONE, '0, sat_sum(hits_before, OFS_W'(page_hits)), 1'b1, 1'b1);
				clear_run();
			end
			return 1'b1;
		endfunction

		function void check_result(logic [2:0] kind, logic [OFS_W-1:0] pos,
			logic [OFS_W-1:0] total, logic exact, logic last);
			result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected result: kind %0d position %h total %h exact %b last %b",
						kind, pos, total, exact, last);
				end
				return;
			end
			want = pending.pop_front();
			if (kind !== want.kind || pos !== want.position || total !== want.total
				|| exact !== want.exact || last !== want.last) begin
				errors++;
				if (errors <= 10) begin
					$display("result mismatch: expected kind %0d position %h total %h exact %b last %b",
						want.kind, want.position, want.total, want.exact, want.last);
					$display("                 got      kind %0d position %h total %h exact %b last %b",
						kind, pos, total, exact, last);
				end
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel, penable, pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [APB_DW-1:0]   pwdata, prdata;
	logic                pready;
	logic                byte_valid, byte_stall;
	logic [7:0]          data_byte;
	logic                end_of_range;
	logic                result_valid, result_stall;
	logic [2:0]          result_kind;
	logic [OFS_W-1:0]    position, match_total;
	logic                total_exact, run_last;

	search_scoreboard    search_sb;
	int                  src_idle, sink_idle;
	int unsigned         items_done, cycles;
	logic [127:0]        cur_pat, cur_msk;
	int                  cur_len;

	masked_byte_pattern_search_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.end_of_range (end_of_range),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_kind  (result_kind),
		.position     (position),
		.match_total  (match_total),
		.total_exact  (total_exact),
		.run_last     (run_last)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < sink_idle);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			search_sb.check_result(result_kind, position, match_total, total_exact, run_last);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] b, logic eor);
		while ($urandom_range(99) < src_idle) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		end_of_range <= eor;
		do @(posedge clk); while (byte_stall);
		if (search_sb.take_byte(b, eor)) items_done++;
	endtask

	task automatic send_run(byte_q_t q);
		foreach (q[i]) send_byte(q[i], i == q.size() - 1);
	endtask

	// drop the request line and let every pending result drain
	task automatic settle();
		byte_valid <= 1'b0;
		end_of_range <= 1'b0;
		while (search_sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		search_sb.set_reg(idx, v);
	endtask

	task automatic apply_config(logic [63:0] pl, logic [63:0] ph, logic [63:0] ml,
		logic [63:0] mh, logic [LEN_CFG_W-1:0] len5, logic [CNT_W-1:0] lim,
		logic [OFS_W-1:0] so, logic [OFS_W-1:0] mb);
		write_reg(REG_PATTERN_LOW, pl);
		write_reg(REG_PATTERN_HIGH, ph);
		write_reg(REG_MASK_LOW, ml);
		write_reg(REG_MASK_HIGH, mh);
		write_reg(REG_PATTERN_LENGTH, 64'(len5));
		write_reg(REG_HIT_LIMIT, 64'(lim));
		write_reg(REG_START_OFFSET, 64'(so));
		write_reg(REG_MATCHES_BEFORE, 64'(mb));
		cur_pat = {ph, pl};
		cur_msk = {mh, ml};
		cur_len = (len5 == 0) ? 1 : (len5 > 16) ? 16 : int'(len5);
	endtask

	task automatic pick_config();
		logic [127:0]         pat, msk;
		logic [7:0]           mb8;
		logic [LEN_CFG_W-1:0] len5;
		logic [CNT_W-1:0]     lim;
		logic [OFS_W-1:0]     so, mb;
		int                   r;
		r = $urandom_range(99);
		if (r < 60) len5 = LEN_CFG_W'($urandom_range(1, 4));
		else if (r < 85) len5 = LEN_CFG_W'($urandom_range(5, 16));
		else if (r < 93) len5 = '0;
		else len5 = LEN_CFG_W'($urandom_range(17, 31));
		// repeated pattern bytes give overlapping hits
		if ($urandom_range(99) < 20) pat = {16{8'($urandom)}};
		else pat = {$urandom, $urandom, $urandom, $urandom};
		for (int i = 0; i < 16; i++) begin
			r = $urandom_range(99);
			if (r < 65) mb8 = 8'hFF;
			else if (r < 85) mb8 = 8'($urandom);
			else if (r < 95) mb8 = 8'h00;
			else mb8 = 8'(1 << $urandom_range(7));
			msk[i*8 +: 8] = mb8;
		end
		if ($urandom_range(99) < 4) msk = '0;
		r = $urandom_range(99);
		if (r < 50) lim = CNT_W'($urandom_range(1, 3));
		else if (r < 75) lim = CNT_W'($urandom_range(4, 20));
		else if (r < 83) lim = '0;
		else if (r < 91) lim = CNT_W'(1048576);
		else lim = '1;
		r = $urandom_range(99);
		if (r < 40) so = '0;
		else if (r < 70) so = OFS_W'({$urandom, $urandom});
		else if (r < 85) so = OFS_MAX - OFS_W'($urandom_range(0, 40));
		else so = OFS_W'($urandom_range(1, 1000));
		r = $urandom_range(99);
		if (r < 50) mb = '0;
		else if (r < 75) mb = OFS_W'({$urandom, $urandom});
		else if (r < 90) mb = OFS_MAX - OFS_W'($urandom_range(0, 5));
		else mb = OFS_W'($urandom_range(1, 100));
		apply_config(pat[63:0], pat[127:64], msk[63:0], msk[127:64], len5, lim, so, mb);
	endtask

	// pattern byte i with random bits where its mask is clear
	function automatic logic [7:0] pattern_like(int i);
		return (cur_pat[i*8 +: 8] & cur_msk[i*8 +: 8]) | (8'($urandom) & ~cur_msk[i*8 +: 8]);
	endfunction

	function automatic byte_q_t make_run();
		byte_q_t q;
		int      target, r, cut;
		bit      noise;
		r = $urandom_range(99);
		if (r < 8 && cur_len > 1) begin
			target = $urandom_range(1, cur_len - 1);
			repeat (target) q = {q, 8'($urandom)};
			return q;
		end
		target = (r < 15) ? $urandom_range(1, 4) : $urandom_range(5, 40);
		noise = (r >= 90);
		while (q.size() < target) begin
			r = $urandom_range(99);
			if (!noise && r < 50) begin
				for (int i = 0; i < cur_len; i++) q = {q, pattern_like(i)};
			end else if (!noise && r < 60) begin
				cut = $urandom_range(1, cur_len);
				for (int i = 0; i < cut; i++) q = {q, pattern_like(i)};
			end else begin
				q = {q, 8'($urandom)};
			end
		end
		return q;
	endfunction

	initial begin
		byte_q_t run;
		search_sb = new();
		items_done = 0;
		cycles = 0;
		src_idle = 34;
		sink_idle = 47;
		cur_pat = '0;
		cur_msk = '1;
		cur_len = 1;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		byte_valid <= 1'b0;
		data_byte <= 8'h00;
		end_of_range <= 1'b0;
		result_stall <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: hit, then truncation at the limit of one, then an ignored tail
		run = '{8'h00, 8'h00, 8'hFF};
		send_run(run);

		// masked three-byte pattern, offsets wrap, totals saturate, hit on the last byte
		settle();
		apply_config(64'h0000_0000_00C3_5AA5, '1, 64'hFFFF_FFFF_FF0F_FFFF, '1,
			LEN_CFG_W'(3), CNT_W'(2), OFS_MAX - 1, OFS_MAX);
		run = '{8'h00, 8'hA5, 8'h5A, 8'hC3, 8'hA5, 8'h5A, 8'hF3};
		send_run(run);
		run = '{8'h7E};
		send_run(run);

		// empty mask within the pattern length, on a three-byte range and on a one-byte range
		settle();
		write_reg(REG_MASK_LOW, '0);
		run = '{8'h00, 8'h00, 8'hFF};
		send_run(run);
		run = '{8'h80};
		send_run(run);

		// length 0 acts as 1; zero hit limit truncates on the first match
		settle();
		apply_config('0, '0, '1, '0, '0, '0, 48'h1234_5678_9ABC, '0);
		run = '{8'h00, 8'h01};
		send_run(run);

		while (items_done < ITEM_TARGET) begin
			if (items_done < ITEM_TARGET / 3) begin
				src_idle = 34;
				sink_idle = 47;
			end else if (items_done < 2 * ITEM_TARGET / 3) begin
				src_idle = 47;
				sink_idle = 34;
			end else begin
				src_idle = 0;
				sink_idle = 0;
			end
			settle();
			pick_config();
			run = make_run();
			send_run(run);
		end
		settle();

		if (search_sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: masked_byte_pattern_search_core.f
src/mbps_pkg.sv
src/mbps_cfg.sv
src/mbps_cell.sv
src/mbps_result_fifo.sv
src/masked_byte_pattern_search_core.sv
src/mbps_checker.sv
verif/tb.sv
